[src/ascp_pkg.sv]
`timescale 1ns / 1ps

package ascp_pkg;

  localparam int ROUNDS = 12;
  localparam int WORDS  = 5;
  localparam int LANE_W = 64;
  localparam int RCNT_W = 4;

  typedef logic [LANE_W-1:0] lane_t;
  typedef logic [WORDS-1:0][LANE_W-1:0] lanes_t;

  // One state word as it enters the block.
  typedef struct packed {
    lane_t               word_zero_in;
    lane_t               word_one_in;
    lane_t               word_two_in;
    lane_t               word_three_in;
    lane_t               word_four_in;
    logic [RCNT_W-1:0]   round_count;
  } in_word_t;

  // One permuted state word as it leaves the block.
  typedef struct packed {
    lane_t word_zero_out;
    lane_t word_one_out;
    lane_t word_two_out;
    lane_t word_three_out;
    lane_t word_four_out;
  } out_word_t;

  // State carried from one pipeline stage to the next.
  typedef struct packed {
    lanes_t            lanes;
    logic [RCNT_W-1:0] rounds;
  } stage_t;

  function automatic logic [7:0] round_const(input logic [RCNT_W-1:0] idx);
    logic [7:0] c;
    begin
      case (idx)
        4'd0:    c = 8'hf0;
        4'd1:    c = 8'he1;
        4'd2:    c = 8'hd2;
        4'd3:    c = 8'hc3;
        4'd4:    c = 8'hb4;
        4'd5:    c = 8'ha5;
        4'd6:    c = 8'h96;
        4'd7:    c = 8'h87;
        4'd8:    c = 8'h78;
        4'd9:    c = 8'h69;
        4'd10:   c = 8'h5a;
        4'd11:   c = 8'h4b;
        default: c = 8'h00;
      endcase
      return c;
    end
  endfunction

  function automatic lane_t rotr(input lane_t v, input int n);
    return (v >> n) | (v << (LANE_W - n));
  endfunction

  // Constant addition, bitsliced S-box and linear diffusion.
  function automatic lanes_t ascon_round(input lanes_t s, input logic [7:0] c);
    lane_t a0, a1, a2, a3, a4;
    lane_t n0, n1, n2, n3, n4;
    lanes_t r;
    begin
      a0 = s[0] ^ s[4];
      a4 = s[4] ^ s[3];
      a2 = s[2] ^ {{(LANE_W-8){1'b0}}, c} ^ s[1];
      a1 = s[1];
      a3 = s[3];
      n0 = ~a0 & a1;
      n1 = ~a1 & a2;
      n2 = ~a2 & a3;
      n3 = ~a3 & a4;
      n4 = ~a4 & a0;
      a0 = a0 ^ n1;
      a1 = a1 ^ n2;
      a2 = a2 ^ n3;
      a3 = a3 ^ n4;
      a4 = a4 ^ n0;
      a1 = a1 ^ a0;
      a0 = a0 ^ a4;
      a3 = a3 ^ a2;
      a2 = ~a2;
      r[0] = a0 ^ rotr(a0, 19) ^ rotr(a0, 28);
      r[1] = a1 ^ rotr(a1, 61) ^ rotr(a1, 39);
      r[2] = a2 ^ rotr(a2, 1)  ^ rotr(a2, 6);
      r[3] = a3 ^ rotr(a3, 10) ^ rotr(a3, 17);
      r[4] = a4 ^ rotr(a4, 7)  ^ rotr(a4, 41);
      return r;
    end
  endfunction

endpackage

[src/ascp_stage.sv]
`timescale 1ns / 1ps

module ascp_stage #(
  parameter int STAGE = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic            prev_valid,
  input  ascp_pkg::stage_t prev_state,
  output logic            valid,
  output ascp_pkg::stage_t state
);
  import ascp_pkg::*;

  localparam logic [RCNT_W-1:0] FIRST_USE = RCNT_W'(ROUNDS - STAGE);
  localparam logic [RCNT_W-1:0] CONST_IDX = RCNT_W'(STAGE);

  stage_t state_next;

  // Apply this stage's round only when the word asks for enough rounds.
  always_comb begin
    state_next.rounds = prev_state.rounds;
    if (prev_state.rounds >= FIRST_USE) begin
      state_next.lanes = ascon_round(prev_state.lanes, round_const(CONST_IDX));
    end else begin
      state_next.lanes = prev_state.lanes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      state <= state_next;
    end
  end

endmodule

[src/ascon_permutation_top.sv]
`timescale 1ns / 1ps
// Ascon permutation, last N of the twelve rounds, one round per pipeline stage.
//
// Input channel: state_valid / state_stall / state_word. A word is taken on a
// rising edge with state_valid high and state_stall low. round_count selects
// the last N rounds; counts above twelve act as twelve, zero passes the
// state through untouched.
// Output channel: result_valid / result_stall / result_word, same handshake.
//
// Throughput is one word per cycle unless a stall holds the pipeline. Twelve
// round stages lie between acceptance and result_valid, each stage doing one
// round (constant add, S-box, diffusion) or passing the state on.
// The last stage is the output register.
//
// Reset (rst, synchronous) empties every stage; words in flight are dropped.
// While result_valid is high and result_stall is high, the whole pipeline
// holds and state_stall rises in the same cycle, so nothing is lost or
// repeated. Bubbles are not squeezed out during a stall.
module ascon_permutation_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               state_valid,
  output logic               state_stall,
  input  ascp_pkg::in_word_t state_word,
  output logic               result_valid,
  input  logic               result_stall,
  output ascp_pkg::out_word_t result_word
);
  import ascp_pkg::*;

  logic              advance;
  stage_t            entry;
  logic   [ROUNDS-1:0] stage_valid;
  stage_t            stage_state [ROUNDS];

  // Advance the pipeline unless the output word is held by the receiver.
  assign advance     = !(result_valid && result_stall);
  assign state_stall = !advance;

  assign entry.lanes[0] = state_word.word_zero_in;
  assign entry.lanes[1] = state_word.word_one_in;
  assign entry.lanes[2] = state_word.word_two_in;
  assign entry.lanes[3] = state_word.word_three_in;
  assign entry.lanes[4] = state_word.word_four_in;
  assign entry.rounds   = state_word.round_count;

  for (genvar g = 0; g < ROUNDS; g++) begin : g_stage
    if (g == 0) begin : g_first
      ascp_stage #(.STAGE(g)) u_stage (
        .clk        (clk),
        .rst        (rst),
        .advance    (advance),
        .prev_valid (state_valid),
        .prev_state (entry),
        .valid      (stage_valid[g]),
        .state      (stage_state[g])
      );
    end else begin : g_rest
      ascp_stage #(.STAGE(g)) u_stage (
        .clk        (clk),
        .rst        (rst),
        .advance    (advance),
        .prev_valid (stage_valid[g-1]),
        .prev_state (stage_state[g-1]),
        .valid      (stage_valid[g]),
        .state      (stage_state[g])
      );
    end
  end

  assign result_valid               = stage_valid[ROUNDS-1];
  assign result_word.word_zero_out  = stage_state[ROUNDS-1].lanes[0];
  assign result_word.word_one_out   = stage_state[ROUNDS-1].lanes[1];
  assign result_word.word_two_out   = stage_state[ROUNDS-1].lanes[2];
  assign result_word.word_three_out = stage_state[ROUNDS-1].lanes[3];
  assign result_word.word_four_out  = stage_state[ROUNDS-1].lanes[4];

  // Pipeline empty straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (stage_valid == '0))
    else $error("pipeline not empty after reset");

  // An unstalled cycle moves the penultimate stage into the output register.
  a_advance_moves: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(state_stall)) |-> (result_valid == $past(stage_valid[ROUNDS-2])))
    else $error("output stage did not take the word behind it");

  // A stalled cycle freezes every valid bit in the pipeline.
  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(state_stall)) |-> $stable(stage_valid))
    else $error("pipeline moved during a stall");

  // Stall towards the source only while an output word is waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    state_stall |-> (result_valid && stage_valid[ROUNDS-1]))
    else $error("source stalled with no waiting output");

endmodule

[tb/ascon_permutation_top_test.sv]
`timescale 1ns / 1ps

module ascon_permutation_top_test;

  import ascp_pkg::*;

  // Give up once this many cycles pass with no word moving on either side.
  localparam int unsigned STUCK_LIMIT = 4000;
  localparam int unsigned RANDOM_WORDS = 1500;
  // Run the last stretch with no idling on either side.
  localparam int unsigned CALM_TAIL = 150;
  localparam int unsigned SHOW_MAX = 100;

  // Hold the expected permutations and compare each result as it leaves the block.
  class perm_ledger;
    out_word_t awaited[$];
    int unsigned faults;
    int unsigned shown;

    function new();
      faults = 0;
      shown = 0;
    endfunction

    // Rotate right by taking the low half of a doubled lane.
    function lane_t spin(lane_t v, int unsigned n);
      logic [2*LANE_W-1:0] d;
      d = {v, v} >> n;
      return d[LANE_W-1:0];
    endfunction

    // Apply the last n of the twelve rounds; counts above twelve run all twelve.
    function out_word_t ascon_permute(in_word_t w);
      lane_t x0, x1, x2, x3, x4;
      lane_t t0, t1, t2, t3, t4;
      lane_t u0, u1, u2, u3, u4;
      logic [7:0] k;
      int unsigned n;
      out_word_t o;
      x0 = w.word_zero_in;
      x1 = w.word_one_in;
      x2 = w.word_two_in;
      x3 = w.word_three_in;
      x4 = w.word_four_in;
      n = (w.round_count > 4'd12) ? 12 : w.round_count;
      for (int r = 12 - n; r < 12; r++) begin
        // Constants run 0xf0, 0xe1, ... : high nibble counts down, low counts up.
        k = {4'(15 - r), 4'(r)};
        x2 = x2 ^ lane_t'(k);
        t0 = x0 ^ x4;
        t4 = x4 ^ x3;
        t2 = x2 ^ x1;
        t1 = x1;
        t3 = x3;
        u0 = t0 ^ (~t1 & t2);
        u1 = t1 ^ (~t2 & t3);
        u2 = t2 ^ (~t3 & t4);
        u3 = t3 ^ (~t4 & t0);
        u4 = t4 ^ (~t0 & t1);
        u1 = u1 ^ u0;
        u0 = u0 ^ u4;
        u3 = u3 ^ u2;
        u2 = ~u2;
        x0 = u0 ^ spin(u0, 19) ^ spin(u0, 28);
        x1 = u1 ^ spin(u1, 61) ^ spin(u1, 39);
        x2 = u2 ^ spin(u2, 1) ^ spin(u2, 6);
        x3 = u3 ^ spin(u3, 10) ^ spin(u3, 17);
        x4 = u4 ^ spin(u4, 7) ^ spin(u4, 41);
      end
      o.word_zero_out  = x0;
      o.word_one_out   = x1;
      o.word_two_out   = x2;
      o.word_three_out = x3;
      o.word_four_out  = x4;
      return o;
    endfunction

    function void note_state(in_word_t w);
      awaited.push_back(ascon_permute(w));
    endfunction

    task flag_mismatch(string what, lane_t got, lane_t want);
      faults++;
      if (shown < SHOW_MAX) begin
        shown++;
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      end
    endtask

    task check_perm(out_word_t got);
      out_word_t want;
      if (awaited.size() == 0) begin
        flag_mismatch("result with nothing awaited", got.word_zero_out, '0);
        return;
      end
      want = awaited.pop_front();
      if (got.word_zero_out !== want.word_zero_out)
        flag_mismatch("word_zero_out", got.word_zero_out, want.word_zero_out);
      if (got.word_one_out !== want.word_one_out)
        flag_mismatch("word_one_out", got.word_one_out, want.word_one_out);
      if (got.word_two_out !== want.word_two_out)
        flag_mismatch("word_two_out", got.word_two_out, want.word_two_out);
      if (got.word_three_out !== want.word_three_out)
        flag_mismatch("word_three_out", got.word_three_out, want.word_three_out);
      if (got.word_four_out !== want.word_four_out)
        flag_mismatch("word_four_out", got.word_four_out, want.word_four_out);
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst;
  logic      state_valid;
  logic      state_stall;
  in_word_t  state_word;
  logic      result_valid;
  logic      result_stall;
  out_word_t result_word;

  perm_ledger ledger = new();

  // Percentage chance of a sender gap before each word; reshuffled in phases.
  int unsigned gap_pct = 0;
  // Set for the tail of the run: no gaps, no stalls.
  bit calm = 1'b0;

  ascon_permutation_top dut (
    .clk          (clk),
    .rst          (rst),
    .state_valid  (state_valid),
    .state_stall  (state_stall),
    .state_word   (state_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample both channels at the edge; everything read here is the pre-edge value,
  // since every input is driven by nonblocking assignment on the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (state_valid && !state_stall)
        ledger.note_state(state_word);
      if (result_valid && !result_stall)
        ledger.check_perm(result_word);
    end
  end

  // Watchdog: count cycles in which no word moves on either channel.
  initial begin
    int unsigned stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((state_valid && !state_stall) || (result_valid && !result_stall))
        stuck = 0;
      else
        stuck++;
    end
    $display("timeout: no word moved for %0d cycles", STUCK_LIMIT);
    $display("** ascon_permutation_top: FAILED **");
    $finish;
  end

  // Receiver: stall in random bursts between free stretches of varied length.
  // Only one nonblocking assignment lands on result_stall per edge.
  initial begin
    result_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      result_stall <= 1'b0;
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(40, 120)) @(posedge clk);
      else
        repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Offer one word and hold it until it is taken. Returns on the accepting edge,
  // so the caller may drive state_valid once more on that same edge.
  task automatic send_state(input in_word_t w);
    if (!calm && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      state_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    state_valid <= 1'b1;
    state_word  <= w;
    do @(posedge clk); while (state_stall);
  endtask

  // Mostly dense random lanes, with the odd extreme or lone bit mixed in.
  function automatic lane_t pick_lane();
    int unsigned sel;
    sel = $urandom_range(0, 11);
    case (sel)
      0:       return '0;
      1:       return '1;
      2:       return lane_t'(1) << $urandom_range(0, LANE_W - 1);
      3:       return ~(lane_t'(1) << $urandom_range(0, LANE_W - 1));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Lean on the two counts that matter in use, but cover every 4-bit value,
  // zero and the saturating ones included.
  function automatic logic [RCNT_W-1:0] pick_rounds();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 3)
      return 4'd12;
    else if (sel < 5)
      return 4'd6;
    else
      return RCNT_W'($urandom_range(0, 15));
  endfunction

  // Directed words: each round count 0..15 over zeros, ones, alternating bits and
  // walking ones, then a few lone-bit and mixed states.
  task automatic run_directed();
    in_word_t w;
    for (int i = 0; i < 16; i++) begin
      case (i % 4)
        0: w = '0;
        1: w = '1;
        2: begin
          w.word_zero_in  = 64'haaaa_aaaa_aaaa_aaaa;
          w.word_one_in   = 64'h5555_5555_5555_5555;
          w.word_two_in   = 64'haaaa_aaaa_aaaa_aaaa;
          w.word_three_in = 64'h5555_5555_5555_5555;
          w.word_four_in  = 64'haaaa_aaaa_aaaa_aaaa;
        end
        default: begin
          w.word_zero_in  = lane_t'(1) << (i * 4);
          w.word_one_in   = lane_t'(1) << (i * 4 + 1);
          w.word_two_in   = lane_t'(1) << (i * 4 + 2);
          w.word_three_in = lane_t'(1) << (i * 4 + 3);
          w.word_four_in  = lane_t'(1) << 63;
        end
      endcase
      w.round_count = RCNT_W'(i);
      send_state(w);
    end
    // Constant-carrying lane all ones, lone bits in lanes four and zero, then its inverse.
    w = '0;
    w.word_two_in = '1;
    w.round_count = 4'd12;
    send_state(w);
    w = '0;
    w.word_four_in = 64'h8000_0000_0000_0000;
    w.round_count = 4'd1;
    send_state(w);
    w = '0;
    w.word_zero_in = 64'h1;
    w.round_count = 4'd6;
    send_state(w);
    w = '1;
    w.word_two_in = '0;
    w.round_count = 4'd15;
    send_state(w);
    w = {pick_lane(), pick_lane(), pick_lane(), pick_lane(), pick_lane(), 4'd0};
    send_state(w);
  endtask

  task automatic run_random();
    in_word_t w;
    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      // Reshuffle the sender's gap rate every so often, no-gap phases included.
      if (i % 64 == 0)
        case ($urandom_range(0, 3))
          0:       gap_pct = 0;
          1:       gap_pct = 10;
          2:       gap_pct = 30;
          default: gap_pct = 60;
        endcase
      if (i == RANDOM_WORDS - CALM_TAIL)
        calm = 1'b1;
      w.word_zero_in  = pick_lane();
      w.word_one_in   = pick_lane();
      w.word_two_in   = pick_lane();
      w.word_three_in = pick_lane();
      w.word_four_in  = pick_lane();
      w.round_count   = pick_rounds();
      send_state(w);
    end
  endtask

  initial begin
    rst          <= 1'b1;
    state_valid  <= 1'b0;
    state_word   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    gap_pct = 25;
    run_directed();
    run_random();
    state_valid <= 1'b0;

    // Drain: wait for every awaited result, then give the pipeline a little longer
    // to show any stray extra word.
    while (ledger.awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (ledger.awaited.size() != 0)
      ledger.flag_mismatch("results never arrived", lane_t'(ledger.awaited.size()), '0);

    if (ledger.faults == 0)
      $display("** ascon_permutation_top: PASSED **");
    else
      $display("** ascon_permutation_top: FAILED **");
    $finish;
  end

endmodule
